// ===== src/keystroke_case_mode_filter_core_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef KEYSTROKE_CASE_MODE_FILTER_CORE_MACROS_SVH
`define KEYSTROKE_CASE_MODE_FILTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define KCMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KCMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KCMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KCMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/kcmf_pkg.sv =====
package kcmf_pkg;

	localparam int MAX_CONTINUE = 8;
	localparam int IDX_W = (MAX_CONTINUE > 1) ? $clog2(MAX_CONTINUE) : 1;
	localparam int CNT_W = $clog2(MAX_CONTINUE + 1);
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
	localparam logic [7:0] KEY_A = 8'h04;
	localparam logic [7:0] KEY_Z = 8'h1D;
	localparam logic [7:0] KEY_SPACE = 8'h2C;
	localparam logic [7:0] KEY_MOD_FIRST = 8'hE0;
	localparam logic [7:0] KEY_MOD_LAST = 8'hE7;
	localparam logic [7:0] MOD_LEFT_SHIFT = 8'h02;
	localparam logic [7:0] MOD_SHORTCUT_MASK = 8'hDD;

	typedef enum logic [1:0] {
		CMD_KEY = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE = 2'd3
	} kcmf_cmd_t;

	typedef enum logic [2:0] {
		REG_DELIM_KEY = 3'd0,
		REG_DELIM_MODS = 3'd1,
		REG_EMIT_DELIM = 3'd2,
		REG_CAP_WORDS = 3'd3,
		REG_CAP_FIRST = 3'd4,
		REG_CAP_ALL = 3'd5,
		REG_CONT_COUNT = 3'd6,
		REG_UNUSED = 3'd7
	} kcmf_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SEARCH
	} kcmf_state_t;

	typedef struct packed {
		logic [15:0] page;
		logic [7:0] id;
		logic [7:0] mods;
	} kcmf_entry_t;

	typedef struct packed {
		logic start;
		logic [CNT_W-1:0] limit;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		kcmf_entry_t wr_data;
		logic [15:0] page;
		logic [7:0] id;
		logic [7:0] mods;
	} kcmf_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} kcmf_rsp_t;

endpackage

// ===== src/kcmf_key_in_if.sv =====
interface kcmf_key_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [15:0] hid_page;
	logic [7:0] keycode;
	logic pressed;
	logic [7:0] implicit_mods;
	logic [7:0] explicit_mods;
	logic [2:0] entry_index;

	modport source (
		output valid, command, hid_page, keycode, pressed, implicit_mods,
			explicit_mods, entry_index,
		input ready
	);
	modport sink (
		input valid, command, hid_page, keycode, pressed, implicit_mods,
			explicit_mods, entry_index,
		output ready
	);
endinterface

// ===== src/kcmf_key_out_if.sv =====
interface kcmf_key_out_if;
	logic valid;
	logic ready;
	logic [15:0] out_page;
	logic [7:0] out_keycode;
	logic [7:0] out_mods;
	logic swallowed;
	logic mode_active;
	logic shift_pending;

	modport source (
		output valid, out_page, out_keycode, out_mods, swallowed, mode_active,
			shift_pending,
		input ready
	);
	modport sink (
		input valid, out_page, out_keycode, out_mods, swallowed, mode_active,
			shift_pending,
		output ready
	);
endinterface

// ===== src/kcmf_match_unit.sv =====
module kcmf_match_unit (
	input logic clk,
	input logic arst_n,
	input kcmf_pkg::kcmf_req_t req,
	output kcmf_pkg::kcmf_rsp_t rsp
);

	kcmf_pkg::kcmf_entry_t table_q [kcmf_pkg::MAX_CONTINUE];
	kcmf_pkg::kcmf_entry_t rd_data_s1;
	logic busy_q;
	logic rd_vld_s1;
	logic done_q;
	logic hit_q;
	logic [kcmf_pkg::CNT_W-1:0] issue_cnt_q;
	logic [kcmf_pkg::CNT_W-1:0] limit_q;
	logic [kcmf_pkg::IDX_W-1:0] rd_addr;
	logic match;
	logic last_cmp;

	assign rd_addr = kcmf_pkg::IDX_W'(issue_cnt_q);
	assign match = rd_vld_s1 && (rd_data_s1.page == req.page) && (rd_data_s1.id == req.id)
		&& ((rd_data_s1.mods & req.mods) == rd_data_s1.mods);
	assign last_cmp = busy_q && rd_vld_s1 && (issue_cnt_q == limit_q);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			table_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_s1 <= table_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q <= 1'b0;
			hit_q <= 1'b0;
			issue_cnt_q <= '0;
			limit_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				hit_q <= 1'b0;
				issue_cnt_q <= '0;
				limit_q <= req.limit;
				rd_vld_s1 <= 1'b0;
				if (req.limit == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (issue_cnt_q != limit_q) begin
					issue_cnt_q <= issue_cnt_q + 1'b1;
					rd_vld_s1 <= 1'b1;
				end else begin
					rd_vld_s1 <= 1'b0;
				end
				if (last_cmp) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit = hit_q;

endmodule

// ===== src/keystroke_case_mode_filter_core.sv =====
// Channel   Direction  Content
// key_in    sink       key event, mode toggle or continue entry write
// key_out   source     one forwarded or swallowed event per request
// apb       slave      configuration registers at byte address 4*i
//
// A request that needs no table lookup is evaluated in ST_EVAL once accepted
// and its result is registered at key_out. A press that may end the mode walks
// the continue table through one entry comparator, one entry per cycle, and its
// result is registered when the walk is done. One request is in flight at a
// time, and a waiting result blocks the next request only while key_out is
// stalled. Reset is asynchronous.
`include "keystroke_case_mode_filter_core_macros.svh"

module keystroke_case_mode_filter_core (
	input logic clk,
	input logic arst_n,
	kcmf_key_in_if.sink key_in,
	kcmf_key_out_if.source key_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [kcmf_pkg::PADDR_W-1:0] paddr,
	input logic [kcmf_pkg::PDATA_W-1:0] pwdata,
	output logic [kcmf_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	logic [7:0] delim_key_q;
	logic [7:0] delim_mods_q;
	logic emit_delim_q;
	logic cap_words_q;
	logic cap_first_q;
	logic cap_all_q;
	logic [3:0] cont_count_q;

	kcmf_pkg::kcmf_state_t state_q, state_d;
	logic active_q, shift_q;
	logic [1:0] cmd_q;
	logic [15:0] page_q;
	logic [7:0] key_q;
	logic pressed_q;
	logic [7:0] imods_q;
	logic [7:0] emods_q;
	logic [2:0] slot_q;

	logic out_valid_q;
	logic [15:0] out_page_q;
	logic [7:0] out_key_q;
	logic [7:0] out_mods_q;
	logic out_swallow_q;
	logic out_active_q;
	logic out_shift_q;

	logic in_accept;
	logic load_out;
	logic flag_we;
	logic act_d, sh_d;
	logic [15:0] res_page;
	logic [7:0] res_key;
	logic [7:0] res_mods;
	logic res_swallow;
	logic need_search;
	logic is_kb;
	logic [kcmf_pkg::CNT_W-1:0] limit;
	logic cfg_wr;
	kcmf_pkg::kcmf_reg_t reg_sel;
	kcmf_pkg::kcmf_req_t req;
	kcmf_pkg::kcmf_rsp_t rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_sel = kcmf_pkg::kcmf_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_key_q <= '0;
			delim_mods_q <= '0;
			emit_delim_q <= 1'b0;
			cap_words_q <= 1'b0;
			cap_first_q <= 1'b0;
			cap_all_q <= 1'b0;
			cont_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				kcmf_pkg::REG_DELIM_KEY: delim_key_q <= pwdata[7:0];
				kcmf_pkg::REG_DELIM_MODS: delim_mods_q <= pwdata[7:0];
				kcmf_pkg::REG_EMIT_DELIM: emit_delim_q <= pwdata[0];
				kcmf_pkg::REG_CAP_WORDS: cap_words_q <= pwdata[0];
				kcmf_pkg::REG_CAP_FIRST: cap_first_q <= pwdata[0];
				kcmf_pkg::REG_CAP_ALL: cap_all_q <= pwdata[0];
				kcmf_pkg::REG_CONT_COUNT: cont_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			kcmf_pkg::REG_DELIM_KEY: prdata[7:0] = delim_key_q;
			kcmf_pkg::REG_DELIM_MODS: prdata[7:0] = delim_mods_q;
			kcmf_pkg::REG_EMIT_DELIM: prdata[0] = emit_delim_q;
			kcmf_pkg::REG_CAP_WORDS: prdata[0] = cap_words_q;
			kcmf_pkg::REG_CAP_FIRST: prdata[0] = cap_first_q;
			kcmf_pkg::REG_CAP_ALL: prdata[0] = cap_all_q;
			kcmf_pkg::REG_CONT_COUNT: prdata[3:0] = cont_count_q;
			default: ;
		endcase
	end

	assign key_in.ready = (state_q == kcmf_pkg::ST_IDLE) && (!out_valid_q || key_out.ready);
	assign in_accept = key_in.valid && key_in.ready;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= key_in.command;
			page_q <= key_in.hid_page;
			key_q <= key_in.keycode;
			pressed_q <= key_in.pressed;
			imods_q <= key_in.implicit_mods;
			emods_q <= key_in.explicit_mods;
			slot_q <= key_in.entry_index;
		end
	end

	assign is_kb = page_q == kcmf_pkg::PAGE_KEYBOARD;
	assign limit = (int'(cont_count_q) > kcmf_pkg::MAX_CONTINUE)
		? kcmf_pkg::CNT_W'(kcmf_pkg::MAX_CONTINUE) : kcmf_pkg::CNT_W'(cont_count_q);

	// Classification of the held request.
	always_comb begin
		res_page = '0;
		res_key = '0;
		res_mods = '0;
		res_swallow = 1'b1;
		act_d = active_q;
		sh_d = shift_q;
		need_search = 1'b0;
		unique case (kcmf_pkg::kcmf_cmd_t'(cmd_q))
			kcmf_pkg::CMD_TOGGLE: begin
				if (pressed_q) begin
					act_d = !active_q;
					sh_d = !active_q && cap_first_q;
				end
			end
			kcmf_pkg::CMD_KEY: begin
				res_page = page_q;
				res_key = key_q;
				res_mods = imods_q;
				res_swallow = 1'b0;
				if (!active_q) begin
				end else if (is_kb && key_q >= kcmf_pkg::KEY_MOD_FIRST
					&& key_q <= kcmf_pkg::KEY_MOD_LAST) begin
				end else if (((imods_q | emods_q) & kcmf_pkg::MOD_SHORTCUT_MASK) != 8'h00) begin
				end else if (is_kb && key_q == kcmf_pkg::KEY_SPACE) begin
					if (pressed_q && cap_words_q) begin
						sh_d = 1'b1;
					end
					if (emit_delim_q) begin
						res_key = delim_key_q;
						res_mods = delim_mods_q;
					end else begin
						res_page = '0;
						res_key = '0;
						res_mods = '0;
						res_swallow = 1'b1;
					end
				end else if (!pressed_q) begin
				end else if (is_kb && key_q >= kcmf_pkg::KEY_A && key_q <= kcmf_pkg::KEY_Z) begin
					if (cap_all_q || shift_q) begin
						res_mods = imods_q | kcmf_pkg::MOD_LEFT_SHIFT;
						sh_d = 1'b0;
					end
				end else begin
					need_search = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		flag_we = 1'b0;
		req = '0;
		req.limit = limit;
		req.page = page_q;
		req.id = key_q;
		req.mods = imods_q | emods_q;
		req.wr_addr = kcmf_pkg::IDX_W'(slot_q);
		req.wr_data = '{page: page_q, id: key_q, mods: imods_q};
		unique case (state_q)
			kcmf_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = kcmf_pkg::ST_EVAL;
				end
			end
			kcmf_pkg::ST_EVAL: begin
				if (need_search) begin
					req.start = 1'b1;
					state_d = kcmf_pkg::ST_SEARCH;
				end else begin
					req.wr_en = (cmd_q == kcmf_pkg::CMD_WRITE)
						&& (int'(slot_q) < kcmf_pkg::MAX_CONTINUE);
					load_out = 1'b1;
					flag_we = 1'b1;
					state_d = kcmf_pkg::ST_IDLE;
				end
			end
			kcmf_pkg::ST_SEARCH: begin
				if (rsp.done) begin
					load_out = 1'b1;
					state_d = kcmf_pkg::ST_IDLE;
				end
			end
			default: state_d = kcmf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kcmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			shift_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (flag_we) begin
				active_q <= act_d;
				shift_q <= sh_d;
			end else if (state_q == kcmf_pkg::ST_SEARCH && rsp.done) begin
				active_q <= rsp.hit;
				shift_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (key_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_page_q <= res_page;
			out_key_q <= res_key;
			out_mods_q <= res_mods;
			out_swallow_q <= res_swallow;
			if (state_q == kcmf_pkg::ST_SEARCH) begin
				out_active_q <= rsp.hit;
				out_shift_q <= 1'b0;
			end else begin
				out_active_q <= act_d;
				out_shift_q <= sh_d;
			end
		end
	end

	assign key_out.valid = out_valid_q;
	assign key_out.out_page = out_page_q;
	assign key_out.out_keycode = out_key_q;
	assign key_out.out_mods = out_mods_q;
	assign key_out.swallowed = out_swallow_q;
	assign key_out.mode_active = out_active_q;
	assign key_out.shift_pending = out_shift_q;

	kcmf_match_unit u_match (
		.clk (clk),
		.arst_n (arst_n),
		.req (req),
		.rsp (rsp)
	);

	`KCMF_ASSERT_NEXT(a_accept_to_eval, clk, arst_n, in_accept, state_q == kcmf_pkg::ST_EVAL)
	`KCMF_ASSERT_SAME(a_done_in_search, clk, arst_n, rsp.done, state_q == kcmf_pkg::ST_SEARCH)
	`KCMF_ASSERT_SAME(a_shift_needs_mode, clk, arst_n, !active_q, !shift_q)
	`KCMF_ASSERT_SAME(a_busy_not_ready, clk, arst_n, state_q != kcmf_pkg::ST_IDLE, !key_in.ready)

endmodule
